// ===== hdl/mmon_pkg.sv =====
// Shared types and constants for the matrix multiply and one-norm unit.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package mmon_pkg;

   localparam int MAX_SIZE = 16;
   localparam int INDEX_W  = 4;
   localparam int ADDR_W   = 2 * INDEX_W;
   localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
   localparam int SIZE_W   = 5;
   localparam int MODE_W   = 2;
   localparam int ELEM_W   = 16;
   localparam int PROD_W   = 2 * ELEM_W;
   localparam int ACC_W    = 40;
   localparam int NORM_W   = 46;

   localparam logic [MODE_W-1:0] MODE_WRITE_A = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE_B = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_READ_C  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MAC,
      ST_DRAIN
   } state_type;

   // Travels with each multiply-accumulate through the pipeline
   typedef struct packed {
      logic               valid;
      logic               first_k;
      logic               last_k;
      logic               first_i;
      logic               last_i;
      logic               last_all;
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
   } mac_tag_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic [ACC_W-1:0]  data;
   } c_write_type;

endpackage

`default_nettype wire

// ===== hdl/mmon_req_if.sv =====
// Request channel interface: valid/ready handshake with the item payload.
// Depends on mmon_pkg for field widths.
`default_nettype none

interface mmon_req_if;
   import mmon_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [MODE_W-1:0]          mode;
   logic [INDEX_W-1:0]         row_index;
   logic [INDEX_W-1:0]         col_index;
   logic signed [ELEM_W-1:0]   element_value;

   modport source (output valid, output mode, output row_index, output col_index,
                   output element_value, input ready);
   modport sink   (input valid, input mode, input row_index, input col_index,
                   input element_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/mmon_rsp_if.sv =====
// Response channel interface: valid/ready handshake with the result payload.
// Depends on mmon_pkg for field widths.
`default_nettype none

interface mmon_rsp_if;
   import mmon_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       status;
   logic signed [ACC_W-1:0]    product_value;
   logic [NORM_W-1:0]          norm_value;

   modport source (output valid, output status, output product_value,
                   output norm_value, input ready);
   modport sink   (input valid, input status, input product_value,
                   input norm_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/matrix_multiply_one_norm_unit.sv =====
// Top level of the matrix multiply and one-norm unit: operand and result memories,
// sequencer and response register. Depends on mmon_pkg, mmon_req_if, mmon_rsp_if
// and mmon_mac_unit.
//
// Usage: each request transaction on req_bus carries a mode. Modes 0 and 1 write one
// Q8.8 element of A or B; mode 3 reads one Q24.16 element of C; mode 2 forms C = A*B
// and the one-norm of C. Every request gives exactly one response on rsp_bus.
// csr_write_* sets the matrix size n (values above 16 act as 16); write it while idle.
// Timing: writes answer in the cycle after acceptance; reads pass the registered C
// memory read, then the response register. A compute walks n*n*n multiply-accumulates
// through the single shared multiplier, one per cycle, then drains a 6-stage pipeline;
// n = 0 answers at once. The request side is not ready during a read or a compute.
// Writes can run one per cycle while the response side keeps up.
// Reset: size 16, norm zero, C reads as zero through per-entry valid bits cleared at
// once; no clearing pass. A and B hold nothing meaningful until written.
// Stall: a response waits in its register while rsp_bus.ready is low; no new request
// is taken until that register is free or being emptied in the same cycle.
`default_nettype none

module matrix_multiply_one_norm_unit (
   input  logic                          clock,
   input  logic                          reset,
   mmon_req_if.sink                      req_bus,
   mmon_rsp_if.source                    rsp_bus,
   input  logic                          csr_write_enable,
   input  logic [mmon_pkg::SIZE_W-1:0]   csr_write_data
);
   import mmon_pkg::*;

   state_type                state_ff, state_in;
   logic [SIZE_W-1:0]        matrix_size_ff;
   logic [SIZE_W-1:0]        n;
   logic                     req_accept, in_range, rsp_free;
   logic [ADDR_W-1:0]        req_addr;

   logic [ELEM_W-1:0]        a_mem [DEPTH];
   logic [ELEM_W-1:0]        b_mem [DEPTH];
   logic [ACC_W-1:0]         c_mem [DEPTH];
   logic [DEPTH-1:0]         c_valid_ff;
   logic [ELEM_W-1:0]        a_rd_ff, b_rd_ff;
   logic [ACC_W-1:0]         c_rd_ff;
   logic                     c_rd_valid_ff, read_inside_ff;

   logic [INDEX_W-1:0]       i_ff, j_ff, k_ff, i_in, j_in, k_in;
   logic                     last_k, last_i, last_j;
   mac_tag_type              tag0, tag1_ff;
   logic                     clear_start;
   c_write_type              c_wr;
   logic [NORM_W-1:0]        norm;
   logic                     mac_done;

   logic                     rsp_valid_ff, rsp_load;
   logic                     rsp_status_ff, rsp_status_in;
   logic [ACC_W-1:0]         rsp_prod_ff, rsp_prod_in;
   logic [NORM_W-1:0]        rsp_norm_ff, rsp_norm_in;

   assign n = (matrix_size_ff > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : matrix_size_ff;

   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && rsp_free;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign in_range      = ({1'b0, req_bus.row_index} < n) && ({1'b0, req_bus.col_index} < n);
   assign req_addr      = {req_bus.row_index, req_bus.col_index};

   assign last_k = ({1'b0, k_ff} == n - SIZE_W'(1));
   assign last_i = ({1'b0, i_ff} == n - SIZE_W'(1));
   assign last_j = ({1'b0, j_ff} == n - SIZE_W'(1));

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_size_ff <= SIZE_W'(MAX_SIZE);
      end else if (csr_write_enable) begin
         matrix_size_ff <= csr_write_data;
      end
   end

   // Operand memories: written by load transactions, read by the sequencer
   always_ff @(posedge clock) begin
      if (req_accept && req_bus.mode == MODE_WRITE_A && in_range) begin
         a_mem[req_addr] <= req_bus.element_value;
      end
      if (req_accept && req_bus.mode == MODE_WRITE_B && in_range) begin
         b_mem[req_addr] <= req_bus.element_value;
      end
      a_rd_ff <= a_mem[{i_ff, k_ff}];
      b_rd_ff <= b_mem[{k_ff, j_ff}];
   end

   // Product memory; entries without a valid bit read as zero
   always_ff @(posedge clock) begin
      if (c_wr.valid) begin
         c_mem[c_wr.addr] <= c_wr.data;
      end
      c_rd_ff        <= c_mem[req_addr];
      c_rd_valid_ff  <= c_valid_ff[req_addr];
      read_inside_ff <= in_range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= '0;
      end else if (clear_start) begin
         c_valid_ff <= '0;
      end else if (c_wr.valid) begin
         c_valid_ff[c_wr.addr] <= 1'b1;
      end
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tag1_ff  <= '0;
      end else begin
         state_ff <= state_in;
         tag1_ff  <= tag0;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_bus.mode == MODE_READ_C) begin
                  state_in = ST_READ;
               end else if (req_bus.mode == MODE_COMPUTE && n != '0) begin
                  state_in = ST_MAC;
               end
            end
         end
         ST_READ:  state_in = ST_IDLE;
         ST_MAC: begin
            if (last_k && last_i && last_j) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      tag0          = '0;
      clear_start   = 1'b0;
      rsp_load      = 1'b0;
      rsp_status_in = 1'b0;
      rsp_prod_in   = '0;
      rsp_norm_in   = norm;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_bus.mode)
                  MODE_WRITE_A, MODE_WRITE_B: begin
                     rsp_load      = 1'b1;
                     rsp_status_in = !in_range;
                  end
                  MODE_COMPUTE: begin
                     clear_start = 1'b1;
                     i_in        = '0;
                     j_in        = '0;
                     k_in        = '0;
                     // empty matrix: nothing to walk, answer now
                     if (n == '0) begin
                        rsp_load    = 1'b1;
                        rsp_norm_in = '0;
                     end
                  end
                  MODE_READ_C: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_load      = 1'b1;
            rsp_status_in = !read_inside_ff;
            rsp_prod_in   = (read_inside_ff && c_rd_valid_ff) ? c_rd_ff : '0;
         end
         ST_MAC: begin
            tag0.valid    = 1'b1;
            tag0.first_k  = (k_ff == '0);
            tag0.last_k   = last_k;
            tag0.first_i  = (i_ff == '0);
            tag0.last_i   = last_i;
            tag0.last_all = last_k && last_i && last_j;
            tag0.row      = i_ff;
            tag0.col      = j_ff;
            // k innermost, then rows, then columns so each column sum closes in order
            k_in = last_k ? '0 : k_ff + INDEX_W'(1);
            if (last_k) begin
               i_in = last_i ? '0 : i_ff + INDEX_W'(1);
               if (last_i) begin
                  j_in = j_ff + INDEX_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            rsp_load = mac_done;
         end
         default: begin
         end
      endcase
   end

   mmon_mac_unit u_mac (
      .clock  (clock),
      .reset  (reset),
      .clear  (clear_start),
      .tag_in (tag1_ff),
      .a_data (a_rd_ff),
      .b_data (b_rd_ff),
      .c_wr   (c_wr),
      .norm   (norm),
      .done   (mac_done)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_prod_ff   <= rsp_prod_in;
         rsp_norm_ff   <= rsp_norm_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.product_value = rsp_prod_ff;
   assign rsp_bus.norm_value    = rsp_norm_ff;

`ifndef SYNTHESIS
   a_c_write_in_compute: assert property (@(posedge clock) disable iff (reset)
      c_wr.valid |-> (state_ff == ST_MAC || state_ff == ST_DRAIN))
      else $error("C memory written outside a compute");

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == ST_DRAIN)
      else $error("MAC pipeline finished outside drain");

   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAC |-> ({1'b0, k_ff} < n && {1'b0, i_ff} < n && {1'b0, j_ff} < n))
      else $error("sequencer index beyond matrix size");

   a_write_answers: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_bus.mode == MODE_WRITE_A || req_bus.mode == MODE_WRITE_B))
      |=> rsp_valid_ff)
      else $error("load transaction gave no response");
`endif

endmodule

`default_nettype wire

// ===== hdl/mmon_mac_unit.sv =====
// Shared multiply-accumulate pipeline plus column-sum and norm tracking.
// Depends on mmon_pkg; fed with registered operand reads by the top level.
`default_nettype none

module mmon_mac_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              clear,
   input  mmon_pkg::mac_tag_type             tag_in,
   input  logic signed [mmon_pkg::ELEM_W-1:0] a_data,
   input  logic signed [mmon_pkg::ELEM_W-1:0] b_data,
   output mmon_pkg::c_write_type             c_wr,
   output logic [mmon_pkg::NORM_W-1:0]       norm,
   output logic                              done
);
   import mmon_pkg::*;

   mac_tag_type              tag2_ff, tag3_ff, tag4_ff, tag5_ff;
   mac_tag_type              tag4_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [ACC_W-1:0]         abs_ff, abs_in;
   logic [NORM_W-1:0]        colsum_ff, colsum_in;
   logic [NORM_W-1:0]        norm_ff;
   logic                     done_ff;

   assign acc_in = (tag2_ff.first_k ? '0 : acc_ff)
                 + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign abs_in = acc_ff[ACC_W-1] ? (~acc_ff + ACC_W'(1)) : acc_ff;
   assign colsum_in = (tag4_ff.first_i ? '0 : colsum_ff)
                    + {{(NORM_W-ACC_W){1'b0}}, abs_ff};

   always_comb begin
      tag4_in = tag3_ff;
      // only finished C elements go on to the column sum
      tag4_in.valid = tag3_ff.valid && tag3_ff.last_k;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
         tag5_ff <= '0;
         norm_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         tag2_ff <= tag_in;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag4_in;
         tag5_ff <= tag4_ff;
         done_ff <= tag5_ff.valid && tag5_ff.last_all;
         if (clear) begin
            norm_ff <= '0;
         end else if (tag5_ff.valid && tag5_ff.last_i && colsum_ff > norm_ff) begin
            norm_ff <= colsum_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_data * b_data;
      if (tag2_ff.valid) begin
         acc_ff <= acc_in;
      end
      abs_ff <= abs_in;
      if (tag4_ff.valid) begin
         colsum_ff <= colsum_in;
      end
   end

   assign c_wr.valid = tag3_ff.valid && tag3_ff.last_k;
   assign c_wr.addr  = {tag3_ff.row, tag3_ff.col};
   assign c_wr.data  = acc_ff;
   assign norm       = norm_ff;
   assign done       = done_ff;

endmodule

`default_nettype wire

// ===== bench/matrix_multiply_one_norm_unit_test.sv =====
// Self-checking bench for matrix_multiply_one_norm_unit: randomised A/B loads, products,
// C reads and size changes, each reply checked against an in-bench model of the unit.
// Depends on mmon_pkg, mmon_req_if, mmon_rsp_if and the unit itself.
`timescale 1ns / 100ps

module matrix_multiply_one_norm_unit_test;
   import mmon_pkg::*;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
      logic [ELEM_W-1:0]  value;
   } matrix_op_type;

   typedef struct packed {
      logic              status;
      logic [ACC_W-1:0]  product;
      logic [NORM_W-1:0] norm;
   } reply_type;

   logic               clock;
   logic               reset;
   logic               csr_write_enable;
   logic [SIZE_W-1:0]  csr_write_data;

   mmon_req_if req_bus ();
   mmon_rsp_if rsp_bus ();

   matrix_multiply_one_norm_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   matrix_op_type op_queue [$];
   reply_type     reply_queue [$];

   // mirror of the unit's state, advanced on each accepted transaction
   logic signed [ELEM_W-1:0] a_mirror [DEPTH];
   logic signed [ELEM_W-1:0] b_mirror [DEPTH];
   logic [ACC_W-1:0]         c_mirror [DEPTH];
   logic [NORM_W-1:0]        norm_mirror;
   logic [SIZE_W-1:0]        size_mirror;

   logic op_taken;
   logic reply_taken;
   bit   sender_steady;
   bit   receiver_steady;
   bit   hold_request;
   int   send_gap;
   int   stall_left;
   int   hold_left;
   int   error_count;

   // stimulus side bookkeeping
   bit   a_loaded [DEPTH];
   bit   b_loaded [DEPTH];
   int   programmed_size;
   int   op_total;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic reply_type model_matrix_op(matrix_op_type op);
      reply_type               rsp;
      int                      n;
      logic                    in_range;
      logic signed [PROD_W-1:0] term;
      logic [ACC_W-1:0]        acc;
      logic [ACC_W-1:0]        mag;
      logic [NORM_W-1:0]       col_sum;
      logic [NORM_W-1:0]       best;
      n = (size_mirror > MAX_SIZE) ? MAX_SIZE : int'(size_mirror);
      in_range = (int'(op.row) < n) && (int'(op.col) < n);
      rsp.status = 1'b0;
      rsp.product = '0;
      case (op.mode)
         MODE_WRITE_A, MODE_WRITE_B: begin
            if (!in_range)
               rsp.status = 1'b1;
            else if (op.mode == MODE_WRITE_A)
               a_mirror[op.row * MAX_SIZE + op.col] = op.value;
            else
               b_mirror[op.row * MAX_SIZE + op.col] = op.value;
         end
         MODE_COMPUTE: begin
            for (int e = 0; e < DEPTH; e++)
               c_mirror[e] = '0;
            for (int i = 0; i < n; i++) begin
               for (int j = 0; j < n; j++) begin
                  acc = '0;
                  for (int k = 0; k < n; k++) begin
                     term = a_mirror[i * MAX_SIZE + k] * b_mirror[k * MAX_SIZE + j];
                     acc = acc + {{(ACC_W - PROD_W){term[PROD_W-1]}}, term};
                  end
                  c_mirror[i * MAX_SIZE + j] = acc;
               end
            end
            best = '0;
            for (int j = 0; j < n; j++) begin
               col_sum = '0;
               for (int i = 0; i < n; i++) begin
                  mag = c_mirror[i * MAX_SIZE + j];
                  if (mag[ACC_W-1])
                     mag = -mag;
                  col_sum = col_sum + {{(NORM_W - ACC_W){1'b0}}, mag};
               end
               if (col_sum > best)
                  best = col_sum;
            end
            norm_mirror = best;
         end
         default: begin
            if (in_range)
               rsp.product = c_mirror[op.row * MAX_SIZE + op.col];
            else
               rsp.status = 1'b1;
         end
      endcase
      rsp.norm = norm_mirror;
      return rsp;
   endfunction

   // driver: one transaction offered at a time, per-item gap drawn after each acceptance
   always @(negedge clock) begin : driver
      matrix_op_type op;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_bus.valid || op_taken) begin
         if (req_bus.valid)
            send_gap = sender_steady ? 0 : $urandom_range(0, 13);
         if (send_gap == 0 && op_queue.size() != 0) begin
            op = op_queue.pop_front();
            req_bus.mode          <= op.mode;
            req_bus.row_index     <= op.row;
            req_bus.col_index     <= op.col;
            req_bus.element_value <= op.value;
            req_bus.valid         <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
            if (send_gap != 0)
               send_gap--;
         end
      end
   end

   // response side: per-reply stall, plus the occasional long hold-off
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else begin
         if (hold_request) begin
            hold_left = 400;
            hold_request = 1'b0;
         end
         if (reply_taken)
            stall_left = receiver_steady ? 0 : $urandom_range(0, 13);
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : monitor
      matrix_op_type op;
      reply_type     want;
      if (reset) begin
         for (int e = 0; e < DEPTH; e++) begin
            a_mirror[e] = '0;
            b_mirror[e] = '0;
            c_mirror[e] = '0;
         end
         norm_mirror = '0;
         size_mirror = SIZE_W'(MAX_SIZE);
         op_taken <= 1'b0;
         reply_taken <= 1'b0;
      end else begin
         op_taken <= req_bus.valid && req_bus.ready;
         reply_taken <= rsp_bus.valid && rsp_bus.ready;
         if (csr_write_enable)
            size_mirror = csr_write_data;
         // predict first so a same-edge reply still finds its expectation
         if (req_bus.valid && req_bus.ready) begin
            op.mode  = req_bus.mode;
            op.row   = req_bus.row_index;
            op.col   = req_bus.col_index;
            op.value = req_bus.element_value;
            reply_queue.push_back(model_matrix_op(op));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (reply_queue.size() == 0) begin
               error_count++;
               $display("%0t: unexpected reply: status %0b product %h norm %h", $time,
                        rsp_bus.status, rsp_bus.product_value, rsp_bus.norm_value);
            end else begin
               want = reply_queue.pop_front();
               if (rsp_bus.status !== want.status) begin
                  error_count++;
                  $display("%0t: status expected %0b, got %0b", $time, want.status,
                           rsp_bus.status);
               end
               if (rsp_bus.product_value !== want.product) begin
                  error_count++;
                  $display("%0t: product expected %h, got %h", $time, want.product,
                           rsp_bus.product_value);
               end
               if (rsp_bus.norm_value !== want.norm) begin
                  error_count++;
                  $display("%0t: norm expected %h, got %h", $time, want.norm,
                           rsp_bus.norm_value);
               end
            end
         end
      end
   end

   function automatic logic [ELEM_W-1:0] pick_element();
      case ($urandom_range(0, 11))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   task automatic queue_op(logic [MODE_W-1:0] mode, int row, int col,
                           logic [ELEM_W-1:0] value);
      matrix_op_type op;
      int            n;
      logic          in_range;
      n = (programmed_size > MAX_SIZE) ? MAX_SIZE : programmed_size;
      in_range = (row < n) && (col < n);
      op.mode  = mode;
      op.row   = INDEX_W'(row);
      op.col   = INDEX_W'(col);
      op.value = value;
      if (in_range && mode == MODE_WRITE_A)
         a_loaded[row * MAX_SIZE + col] = 1'b1;
      if (in_range && mode == MODE_WRITE_B)
         b_loaded[row * MAX_SIZE + col] = 1'b1;
      // out-of-range writes are dropped by the unit, so they do not count
      if (in_range || mode == MODE_COMPUTE || mode == MODE_READ_C)
         op_total++;
      op_queue.push_back(op);
   endtask

   task automatic wait_until_idle();
      do @(posedge clock); while (op_queue.size() != 0 || req_bus.valid);
      do @(negedge clock); while (reply_queue.size() != 0);
   endtask

   task automatic program_size(int value);
      wait_until_idle();
      csr_write_data   <= SIZE_W'(value);
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      programmed_size = value;
   endtask

   // loads every operand still missing inside the size, then a random mix
   task automatic run_random_phase(int count);
      int                n;
      int                computes;
      int                pick;
      int                row;
      int                col;
      logic [MODE_W-1:0] mode;
      n = (programmed_size > MAX_SIZE) ? MAX_SIZE : programmed_size;
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c < n; c++) begin
            if (!a_loaded[r * MAX_SIZE + c])
               queue_op(MODE_WRITE_A, r, c, pick_element());
            if (!b_loaded[r * MAX_SIZE + c])
               queue_op(MODE_WRITE_B, r, c, pick_element());
         end
      end
      computes = 0;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (n == 0 && pick < 85)
            pick = 85;
         if (n == MAX_SIZE && pick >= 85 && pick < 90)
            pick = 80;
         // large products are slow; keep them few
         if (pick >= 90 && n >= 12 && computes >= 2)
            pick = 80;
         if (pick < 85) begin
            mode = (pick < 35) ? MODE_WRITE_A : (pick < 70) ? MODE_WRITE_B : MODE_READ_C;
            queue_op(mode, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                     pick_element());
         end else if (pick < 90) begin
            row = $urandom_range(0, 15);
            col = $urandom_range(0, 15);
            if ($urandom_range(0, 1))
               row = $urandom_range(n, 15);
            else
               col = $urandom_range(n, 15);
            case ($urandom_range(0, 2))
               0:       mode = MODE_WRITE_A;
               1:       mode = MODE_WRITE_B;
               default: mode = MODE_READ_C;
            endcase
            queue_op(mode, row, col, pick_element());
         end else begin
            computes++;
            queue_op(MODE_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                     ELEM_W'($urandom));
         end
      end
   endtask

   initial begin : stimulus
      int phase;
      int next_size;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_WRITE_A;
      req_bus.row_index = '0;
      req_bus.col_index = '0;
      req_bus.element_value = '0;
      rsp_bus.ready = 1'b0;
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
      hold_request = 1'b0;
      error_count = 0;
      programmed_size = MAX_SIZE;
      op_total = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // C reads back as zero straight out of reset
      queue_op(MODE_READ_C, 0, 0, 16'h0000);
      queue_op(MODE_READ_C, 15, 15, 16'hFFFF);

      program_size(2);
      queue_op(MODE_WRITE_A, 0, 0, 16'h7FFF);
      queue_op(MODE_WRITE_A, 0, 1, 16'h8000);
      queue_op(MODE_WRITE_A, 1, 0, 16'h0100);
      queue_op(MODE_WRITE_A, 1, 1, 16'hFFFF);
      queue_op(MODE_WRITE_B, 0, 0, 16'h8000);
      queue_op(MODE_WRITE_B, 0, 1, 16'h7FFF);
      queue_op(MODE_WRITE_B, 1, 0, 16'h8000);
      queue_op(MODE_WRITE_B, 1, 1, 16'h0001);
      queue_op(MODE_WRITE_A, 2, 0, 16'h1234);
      queue_op(MODE_WRITE_B, 0, 15, 16'h5555);
      queue_op(MODE_READ_C, 15, 15, 16'h0000);
      queue_op(MODE_COMPUTE, 0, 0, 16'h0000);
      queue_op(MODE_READ_C, 0, 0, 16'h0000);
      queue_op(MODE_READ_C, 0, 1, 16'h0000);
      queue_op(MODE_READ_C, 1, 0, 16'h0000);
      queue_op(MODE_READ_C, 1, 1, 16'h0000);
      queue_op(MODE_READ_C, 1, 2, 16'h0000);
      queue_op(MODE_COMPUTE, 15, 15, 16'hFFFF);

      // zero size: everything out of range, compute clears C and the norm
      program_size(0);
      queue_op(MODE_COMPUTE, 0, 0, 16'h0000);
      queue_op(MODE_WRITE_A, 0, 0, 16'h7FFF);
      queue_op(MODE_READ_C, 0, 0, 16'h0000);
      program_size(2);
      queue_op(MODE_READ_C, 1, 1, 16'h0000);

      phase = 0;
      while (op_total < 1600) begin
         case (phase)
            0:  next_size = 1;
            1:  next_size = 16;
            2:  next_size = 3;
            3:  next_size = 31;
            4:  next_size = 0;
            5:  next_size = 5;
            6:  next_size = 2;
            7:  next_size = 17;
            8:  next_size = 8;
            9:  next_size = 1;
            default: begin
               next_size = $urandom_range(0, 31);
               if (next_size >= 12 && $urandom_range(0, 3) != 0)
                  next_size = $urandom_range(0, 11);
            end
         endcase
         program_size(next_size);
         sender_steady = ($urandom_range(0, 3) == 0);
         receiver_steady = ($urandom_range(0, 3) == 0);
         run_random_phase(100);
         if (phase % 4 == 1) begin
            sender_steady = 1'b1;
            hold_request = 1'b1;
         end
         phase++;
      end

      wait_until_idle();
      repeat (16) @(posedge clock);
      @(negedge clock);
      if (error_count == 0)
         $display("matrix_multiply_one_norm_unit regression: pass");
      else
         $display("matrix_multiply_one_norm_unit regression: fail");
      $finish;
   end

   initial begin : watchdog
      #(20_000_000);
      $display("matrix_multiply_one_norm_unit regression: fail");
      $finish;
   end

endmodule
